// File: hw/rtl/rfg_pkg.sv
// rfg_pkg: widths, types, register indexes and the saturation helper
// shared by the region fade gain block. No dependencies.
package rfg_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int POSITION_BITS = 32;

    // configuration register widths
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int FADE_W     = 24;
    localparam int VOL_W      = 16;
    localparam int SEEK_W     = 32;

    // fade ratio is unsigned Q0.16, gains go up to 1.0 so they need one more bit
    localparam int RATIO_W = 16;
    localparam int GAIN_W  = RATIO_W + 1;
    localparam int DIV_CNT_W = $clog2(RATIO_W);

    // shared multiplier: signed a by signed b
    localparam int MUL_A_W = ((SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W) + 1;
    localparam int MUL_B_W = ((GAIN_W > VOL_W) ? GAIN_W : VOL_W) + 1;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int VOL_SHIFT = VOL_W - 1;
    localparam int Y_W = MUL_P_W - VOL_SHIFT;

    localparam logic [GAIN_W-1:0] GAIN_ONE  = GAIN_W'(1) << RATIO_W;
    localparam logic [GAIN_W-1:0] GAIN_ZERO = '0;
    localparam logic [VOL_W-1:0]  VOL_UNITY = VOL_W'(1) << VOL_SHIFT;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_POSITION    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_LENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_VOLUME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE     = 3'd5;

    typedef logic signed [SAMPLE_BITS-1:0] smp_t;
    typedef logic [POSITION_BITS-1:0]      pos_t;
    typedef logic signed [MUL_A_W-1:0]     mul_a_t;
    typedef logic signed [MUL_B_W-1:0]     mul_b_t;
    typedef logic signed [MUL_P_W-1:0]     mul_p_t;

    typedef struct packed {
        logic              start;
        logic [FADE_W-1:0] dividend;
        logic [FADE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [RATIO_W-1:0] quotient;
    } div_rsp_t;

    // clamp a wide signed value to the sample range
    function automatic smp_t sat_sample(input logic signed [Y_W-1:0] y);
        logic ovf;
        smp_t res;
        ovf = (y[Y_W-1:SAMPLE_BITS-1] != {(Y_W-SAMPLE_BITS+1){y[Y_W-1]}});
        if (!ovf) begin
            res = y[SAMPLE_BITS-1:0];
        end else if (y[Y_W-1]) begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/rfg_div.sv
// rfg_div: restoring serial divider, one quotient bit per cycle,
// gives floor(dividend * 2^16 / divisor) for dividend < divisor. Uses rfg_pkg.
module rfg_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  rfg_pkg::div_req_t req,
    output rfg_pkg::div_rsp_t rsp
);
    import rfg_pkg::*;

    logic [FADE_W-1:0]    rem_reg, rem_next;
    logic [FADE_W-1:0]    den_reg, den_next;
    logic [RATIO_W-1:0]   quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [FADE_W:0] shifted;
    logic [FADE_W:0] trial;

    // remainder stays below the divisor, so the shifted value fits one more bit
    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, den_reg};

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.dividend;
            den_next  = req.divisor;
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[FADE_W]) begin
                rem_next = trial[FADE_W-1:0];
                quo_next = {quo_reg[RATIO_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[FADE_W-1:0];
                quo_next = {quo_reg[RATIO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(RATIO_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: hw/rtl/rfg_mul.sv
// rfg_mul: shared signed multiplier with a registered product,
// used for the fade squares, the gain product and the sample scaling. Uses rfg_pkg.
module rfg_mul (
    input  logic            aclk,
    input  rfg_pkg::mul_a_t a,
    input  rfg_pkg::mul_b_t b,
    output rfg_pkg::mul_p_t p
);
    import rfg_pkg::*;

    mul_p_t p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/region_fade_gain.sv
// region_fade_gain: square-law fade-in/fade-out and volume for a sample stream.
// Instantiates rfg_div and rfg_mul, uses rfg_pkg.
//
// Usage:
//   Registers are written through cfg_wr_en / cfg_index / cfg_wr_data while the
//   block is idle; writes take effect at once, there is no read-back.
//   The s_ channel carries requests: a seek request (s_req_type high) sets the
//   source position to region_offset + s_seek_position and gives no result; a
//   sample request gives one result on the m_ channel and advances the position.
//   Each fade whose window contains the position adds a divide and a squaring
//   step to a sample request, and in mono the right-channel steps are skipped.
//   The fade ratios come from one serial divider and all products from one
//   shared multiplier, stepped by the sequencer; s_ready is high only while
//   idle, so one sample request is in flight at a time. A seek request is
//   handled in idle and leaves the sequencer there.
//   A finished result sits in the output register; a new request is accepted
//   while it waits, and a stalled receiver holds the sequencer in its last step
//   until the output register frees up.
//   Reset clears the position, the registers (volume to unity) and m_valid.
module region_fade_gain (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_wr_en,
    input  logic [rfg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfg_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [rfg_pkg::SEEK_W-1:0]       s_seek_position,
    input  rfg_pkg::smp_t                    s_sample_left,
    input  rfg_pkg::smp_t                    s_sample_right,
    input  logic                             s_block_end,

    output logic                             m_valid,
    input  logic                             m_ready,
    output rfg_pkg::smp_t                    m_out_left,
    output rfg_pkg::smp_t                    m_out_right,
    output logic                             m_out_block_end
);
    import rfg_pkg::*;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
    localparam logic [ST_W-1:0] S_IN_SEL   = 5'd1;
    localparam logic [ST_W-1:0] S_IN_DIV   = 5'd2;
    localparam logic [ST_W-1:0] S_IN_SQ    = 5'd3;
    localparam logic [ST_W-1:0] S_IN_CAP   = 5'd4;
    localparam logic [ST_W-1:0] S_OUT_SEL  = 5'd5;
    localparam logic [ST_W-1:0] S_OUT_DIV  = 5'd6;
    localparam logic [ST_W-1:0] S_OUT_SQ   = 5'd7;
    localparam logic [ST_W-1:0] S_OUT_CAP  = 5'd8;
    localparam logic [ST_W-1:0] S_GAIN     = 5'd9;
    localparam logic [ST_W-1:0] S_GAIN_CAP = 5'd10;
    localparam logic [ST_W-1:0] S_L_MUL    = 5'd11;
    localparam logic [ST_W-1:0] S_L_VOL    = 5'd12;
    localparam logic [ST_W-1:0] S_L_SAT    = 5'd13;
    localparam logic [ST_W-1:0] S_R_MUL    = 5'd14;
    localparam logic [ST_W-1:0] S_R_VOL    = 5'd15;
    localparam logic [ST_W-1:0] S_R_SAT    = 5'd16;
    localparam logic [ST_W-1:0] S_DONE     = 5'd17;

    // configuration
    pos_t              offset_reg;
    pos_t              end_pos_reg;
    logic [FADE_W-1:0] fade_in_reg;
    logic [FADE_W-1:0] fade_out_reg;
    logic [VOL_W-1:0]  volume_reg;
    logic              stereo_reg;

    // sequencer state and datapath registers
    logic [ST_W-1:0]   state_reg, state_next;
    pos_t              pos_reg, pos_next;
    logic [GAIN_W-1:0] gin_reg, gin_next;
    logic [GAIN_W-1:0] gout_reg, gout_next;
    logic [GAIN_W-1:0] g_reg, g_next;
    smp_t              smp_left_reg, smp_left_next;
    smp_t              smp_right_reg, smp_right_next;
    logic              blk_end_reg, blk_end_next;
    smp_t              res_left_reg, res_left_next;
    smp_t              res_right_reg, res_right_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    smp_t              out_left_reg, out_left_next;
    smp_t              out_right_reg, out_right_next;
    logic              out_blk_reg, out_blk_next;

    div_req_t div_req;
    div_rsp_t div_rsp;
    mul_a_t   mul_a;
    mul_b_t   mul_b;
    mul_p_t   mul_p;

    pos_t     d_in, d_out;
    logic     in_before, in_window, out_after, out_window;
    logic     s_fire;

    rfg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    rfg_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;

    // fade windows
    assign d_in       = pos_reg - offset_reg;
    assign d_out      = end_pos_reg - pos_reg;
    assign in_before  = (pos_reg < offset_reg);
    assign in_window  = !in_before && (d_in < POSITION_BITS'(fade_in_reg));
    assign out_after  = (pos_reg > end_pos_reg);
    assign out_window = !out_after && (d_out < POSITION_BITS'(fade_out_reg));

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        gin_next       = gin_reg;
        gout_next      = gout_reg;
        g_next         = g_reg;
        smp_left_next  = smp_left_reg;
        smp_right_next = smp_right_reg;
        blk_end_next   = blk_end_reg;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        m_valid_next   = m_valid_reg;
        out_left_next  = out_left_reg;
        out_right_next = out_right_reg;
        out_blk_next   = out_blk_reg;

        div_req.start    = 1'b0;
        div_req.dividend = (state_reg == S_IN_SEL) ? d_in[FADE_W-1:0] : d_out[FADE_W-1:0];
        div_req.divisor  = (state_reg == S_IN_SEL) ? fade_in_reg : fade_out_reg;

        mul_a = mul_a_t'(div_rsp.quotient);
        mul_b = mul_b_t'(div_rsp.quotient);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    if (s_req_type) begin
                        pos_next = offset_reg + POSITION_BITS'(s_seek_position);
                    end else begin
                        smp_left_next  = s_sample_left;
                        smp_right_next = s_sample_right;
                        blk_end_next   = s_block_end;
                        state_next     = S_IN_SEL;
                    end
                end
            end
            S_IN_SEL: begin
                if (fade_in_reg == '0) begin
                    gin_next   = GAIN_ONE;
                    state_next = S_OUT_SEL;
                end else if (in_before) begin
                    gin_next   = GAIN_ZERO;
                    state_next = S_OUT_SEL;
                end else if (in_window) begin
                    div_req.start = 1'b1;
                    state_next    = S_IN_DIV;
                end else begin
                    gin_next   = GAIN_ONE;
                    state_next = S_OUT_SEL;
                end
            end
            S_IN_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_IN_SQ;
                end
            end
            S_IN_SQ: begin
                // ratio squared, operands are the divider quotient
                state_next = S_IN_CAP;
            end
            S_IN_CAP: begin
                gin_next   = {1'b0, mul_p[2*RATIO_W-1:RATIO_W]};
                state_next = S_OUT_SEL;
            end
            S_OUT_SEL: begin
                if (fade_out_reg == '0) begin
                    gout_next  = GAIN_ONE;
                    state_next = S_GAIN;
                end else if (out_after) begin
                    gout_next  = GAIN_ZERO;
                    state_next = S_GAIN;
                end else if (out_window) begin
                    div_req.start = 1'b1;
                    state_next    = S_OUT_DIV;
                end else begin
                    gout_next  = GAIN_ONE;
                    state_next = S_GAIN;
                end
            end
            S_OUT_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_OUT_SQ;
                end
            end
            S_OUT_SQ: begin
                state_next = S_OUT_CAP;
            end
            S_OUT_CAP: begin
                gout_next  = {1'b0, mul_p[2*RATIO_W-1:RATIO_W]};
                state_next = S_GAIN;
            end
            S_GAIN: begin
                mul_a      = mul_a_t'(gin_reg);
                mul_b      = mul_b_t'(gout_reg);
                state_next = S_GAIN_CAP;
            end
            S_GAIN_CAP: begin
                g_next     = mul_p[RATIO_W +: GAIN_W];
                state_next = S_L_MUL;
            end
            S_L_MUL: begin
                mul_a      = mul_a_t'(smp_left_reg);
                mul_b      = mul_b_t'(g_reg);
                state_next = S_L_VOL;
            end
            S_L_VOL: begin
                // floor of s*g / 2^16 is an arithmetic shift of the product
                mul_a      = mul_a_t'(smp_t'(mul_p[RATIO_W +: SAMPLE_BITS]));
                mul_b      = mul_b_t'(volume_reg);
                state_next = S_L_SAT;
            end
            S_L_SAT: begin
                res_left_next = sat_sample(mul_p[MUL_P_W-1:VOL_SHIFT]);
                if (stereo_reg) begin
                    state_next = S_R_MUL;
                end else begin
                    res_right_next = '0;
                    state_next     = S_DONE;
                end
            end
            S_R_MUL: begin
                mul_a      = mul_a_t'(smp_right_reg);
                mul_b      = mul_b_t'(g_reg);
                state_next = S_R_VOL;
            end
            S_R_VOL: begin
                mul_a      = mul_a_t'(smp_t'(mul_p[RATIO_W +: SAMPLE_BITS]));
                mul_b      = mul_b_t'(volume_reg);
                state_next = S_R_SAT;
            end
            S_R_SAT: begin
                res_right_next = sat_sample(mul_p[MUL_P_W-1:VOL_SHIFT]);
                state_next     = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    out_left_next  = res_left_reg;
                    out_right_next = res_right_reg;
                    out_blk_next   = blk_end_reg;
                    pos_next       = pos_reg + 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
            offset_reg   <= '0;
            end_pos_reg  <= '0;
            fade_in_reg  <= '0;
            fade_out_reg <= '0;
            volume_reg   <= VOL_UNITY;
            stereo_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_REGION_OFFSET:   offset_reg   <= POSITION_BITS'(cfg_wr_data);
                    CFG_END_POSITION:    end_pos_reg  <= POSITION_BITS'(cfg_wr_data);
                    CFG_FADE_IN_LENGTH:  fade_in_reg  <= cfg_wr_data[FADE_W-1:0];
                    CFG_FADE_OUT_LENGTH: fade_out_reg <= cfg_wr_data[FADE_W-1:0];
                    CFG_REGION_VOLUME:   volume_reg   <= cfg_wr_data[VOL_W-1:0];
                    CFG_STEREO_MODE:     stereo_reg   <= cfg_wr_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        gin_reg       <= gin_next;
        gout_reg      <= gout_next;
        g_reg         <= g_next;
        smp_left_reg  <= smp_left_next;
        smp_right_reg <= smp_right_next;
        blk_end_reg   <= blk_end_next;
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        out_left_reg  <= out_left_next;
        out_right_reg <= out_right_next;
        out_blk_reg   <= out_blk_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_left      = out_left_reg;
    assign m_out_right     = out_right_reg;
    assign m_out_block_end = out_blk_reg;

    // seek lands on region offset plus the requested position
    a_seek_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_req_type) |=> (pos_reg == $past(offset_reg + POSITION_BITS'(s_seek_position))))
        else $error("seek position mismatch");

    // the divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_IN_DIV || state_reg == S_OUT_DIV))
        else $error("divider done outside a wait state");

    // no divide in flight while idle
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while idle");

    // a sample request leaves idle, a seek request stays there
    a_sample_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_req_type) |=> (state_reg == S_IN_SEL))
        else $error("sample request did not start the sequencer");

endmodule
